// File: src/rivp_pkg.sv
// shared types, constants and the gaussian lookup table of the radial impact velocity block
// no dependencies
package rivp_pkg;

    localparam int EXP_TABLE_DEPTH     = 256;
    localparam int COORD_FRACTION_BITS = 24;

    // r2 is the exact 65-bit sum of squares shifted down to Q17.16
    localparam int R2_SHIFT = 2 * COORD_FRACTION_BITS - 16;
    localparam int R2_W     = (R2_SHIFT == 0) ? 64 : 65 - R2_SHIFT;
    localparam int CMP_W    = (R2_W > 32) ? R2_W : 32;
    localparam int MUL_W    = (R2_W < 40) ? R2_W : 40;
    localparam int R2X_W    = (R2_W > 40) ? R2_W : 41;
    localparam int PROD_W   = MUL_W + 32;

    localparam int T_W       = 24;
    localparam int P_W       = 17;
    localparam int FRAC_BITS = 21;
    localparam int TAB_AW    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W     = T_W + TAB_AW;
    localparam int IDX_W     = POS_W - FRAC_BITS;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
    localparam logic [P_W-1:0] P_ONE = P_W'(65536);

    localparam logic [1:0] SHAPE_GAUSS     = 2'd0;
    localparam logic [1:0] SHAPE_CIRCULAR  = 2'd1;
    localparam logic [1:0] SHAPE_PARABOLIC = 2'd2;
    localparam logic [1:0] SHAPE_GAUSS_ALT = 2'd3;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Z       = 3'd7;

    typedef struct packed {
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               update;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] ctr_x;
        logic signed [31:0] ctr_y;
        logic [31:0]        inv_sigma_sq;
        logic [31:0]        cutoff_sq;
        logic [1:0]         shape_mode;
        logic signed [31:0] coef_x;
        logic signed [31:0] coef_y;
        logic signed [31:0] coef_z;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic in_range;
    } t_ctl;

    typedef logic [P_W-1:0] t_exp_tab [0:EXP_TABLE_DEPTH];

    // exp(-16k/depth) in Q1.16, stepped in Q2.30 from a taylor series step
    function automatic t_exp_tab build_exp_tab();
        logic [63:0] x;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] step;
        logic [63:0] acc;
        t_exp_tab    tab;
        x    = (64'd16 << 30) / EXP_TABLE_DEPTH;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        term = 64'd1 << 30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        step = (neg > pos) ? 64'd0 : pos - neg;
        acc  = 64'd1 << 30;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            if (k > 0) begin
                acc = (acc * step + (64'd1 << 29)) >> 30;
            end
            tab[k] = P_W'((acc + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

// File: src/rivp_geom.sv
// distance stages: offset from the centre, squares, r2 and cutoff test
// depends on rivp_pkg
module rivp_geom (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  rivp_pkg::t_in_item        i_in,
    input  rivp_pkg::t_cfg            i_cfg,
    output rivp_pkg::t_ctl            o_ctl,
    output logic [rivp_pkg::R2_W-1:0] o_r2
);
    import rivp_pkg::*;

    logic signed [32:0] dx, dy;
    logic [31:0]        n_ax, n_ay;
    logic [31:0]        r_ax, r_ay;
    logic [63:0]        r_sqx, r_sqy;
    logic [64:0]        sum;
    logic [R2_W-1:0]    n_r2, r_r2;
    logic               n_in_range;
    logic               r_v1, r_v2;
    t_ctl               r_ctl;

    always_comb begin
        dx   = {i_in.node_x[31], i_in.node_x} - {i_cfg.ctr_x[31], i_cfg.ctr_x};
        dy   = {i_in.node_y[31], i_in.node_y} - {i_cfg.ctr_y[31], i_cfg.ctr_y};
        n_ax = dx[32] ? 32'(-dx) : dx[31:0];
        n_ay = dy[32] ? 32'(-dy) : dy[31:0];
    end

    always_comb begin
        sum = {1'b0, r_sqx} + {1'b0, r_sqy};
        if (R2_SHIFT == 0) begin
            n_r2 = sum[64] ? {R2_W{1'b1}} : R2_W'(sum);
        end else begin
            n_r2 = R2_W'(sum >> R2_SHIFT);
        end
        // all ones disables the cutoff, equality counts as inside
        n_in_range = (i_cfg.cutoff_sq == 32'hFFFF_FFFF)
                     || (CMP_W'(n_r2) <= CMP_W'(i_cfg.cutoff_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_ctl <= '0;
        end else if (i_en) begin
            r_v1           <= i_valid;
            r_v2           <= r_v1;
            r_ctl.valid    <= r_v2;
            r_ctl.in_range <= n_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_r2  <= n_r2;
        end
    end

    assign o_ctl = r_ctl;
    assign o_r2  = r_r2;

endmodule

// File: src/rivp_shape.sv
// profile stages: normalised radius, table lookup with interpolation, shape select
// depends on rivp_pkg
module rivp_shape (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  rivp_pkg::t_ctl            i_ctl,
    input  logic [rivp_pkg::R2_W-1:0] i_r2,
    input  rivp_pkg::t_cfg            i_cfg,
    output rivp_pkg::t_ctl            o_ctl,
    output logic [rivp_pkg::P_W-1:0]  o_p
);
    import rivp_pkg::*;

    t_ctl                 r_ctl4, r_ctl5, r_ctl6, r_ctl7;
    logic [R2X_W-1:0]     r2x;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_big;
    logic [PROD_W-17:0]   q;
    logic [T_W-1:0]       n_t, r_t;
    logic [POS_W-1:0]     pos;
    logic [IDX_W-1:0]     idx;
    logic                 n_oob;
    logic [TAB_AW-1:0]    i0;
    logic [P_W-1:0]       r_a, r_b, r_tlo;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_oob, r_le_one;
    logic [P_W-1:0]       diff;
    logic [P_W+FRAC_BITS-1:0] dprod;
    logic [P_W-1:0]       n_p, r_p;

    assign r2x = R2X_W'(i_r2);

    // saturate t to Q8.16 all ones; a zero inv_sigma_sq gives t of zero
    always_comb begin
        q = r_prod[PROD_W-1:16];
        if (i_cfg.inv_sigma_sq == 32'd0) begin
            n_t = '0;
        end else if (r_big || (|q[PROD_W-17:T_W])) begin
            n_t = T_MAX;
        end else begin
            n_t = q[T_W-1:0];
        end
    end

    always_comb begin
        pos   = POS_W'(r_t) * POS_W'(EXP_TABLE_DEPTH);
        idx   = pos[POS_W-1:FRAC_BITS];
        n_oob = idx >= IDX_W'(EXP_TABLE_DEPTH);
        i0    = n_oob ? '0 : TAB_AW'(idx);
    end

    always_comb begin
        diff  = (r_a >= r_b) ? r_a - r_b : r_b - r_a;
        dprod = (P_W+FRAC_BITS)'(diff) * (P_W+FRAC_BITS)'(r_frac);
        case (i_cfg.shape_mode)
            SHAPE_CIRCULAR:  n_p = r_le_one ? P_ONE : '0;
            SHAPE_PARABOLIC: n_p = r_le_one ? P_ONE - r_tlo : '0;
            default: begin
                if (r_oob) begin
                    n_p = '0;
                end else if (r_a >= r_b) begin
                    n_p = r_a - P_W'(dprod >> FRAC_BITS);
                end else begin
                    n_p = r_a + P_W'(dprod >> FRAC_BITS);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
            r_ctl7 <= '0;
        end else if (i_en) begin
            r_ctl4 <= i_ctl;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
            r_ctl7 <= r_ctl6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= PROD_W'(MUL_W'(i_r2)) * PROD_W'(i_cfg.inv_sigma_sq);
            r_big    <= |r2x[R2X_W-1:40];
            r_t      <= n_t;
            r_a      <= EXP_TAB[i0];
            r_b      <= EXP_TAB[i0 + TAB_AW'(1)];
            r_frac   <= pos[FRAC_BITS-1:0];
            r_oob    <= n_oob;
            r_le_one <= r_t <= T_W'(P_ONE);
            r_tlo    <= r_t[P_W-1:0];
            r_p      <= n_p;
        end
    end

    assign o_ctl = r_ctl7;
    assign o_p   = r_p;

endmodule

// File: src/rivp_scale.sv
// output stage: profile times the three velocity coefficients, rounded, into the output register
// depends on rivp_pkg
module rivp_scale (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  rivp_pkg::t_ctl           i_ctl,
    input  logic [rivp_pkg::P_W-1:0] i_p,
    input  rivp_pkg::t_cfg           i_cfg,
    output logic                     o_valid,
    output rivp_pkg::t_out_item      o_out
);
    import rivp_pkg::*;

    logic signed [P_W:0]  ps;
    logic signed [P_W+32:0] px, py, pz;
    logic                 r_valid;
    t_out_item            n_out, r_out;

    // round to nearest, ties toward +inf
    always_comb begin
        ps = $signed({1'b0, i_p});
        px = i_cfg.coef_x * ps + (P_W+33)'(32768);
        py = i_cfg.coef_y * ps + (P_W+33)'(32768);
        pz = i_cfg.coef_z * ps + (P_W+33)'(32768);
        if (i_ctl.in_range) begin
            n_out.vel_x  = px[47:16];
            n_out.vel_y  = py[47:16];
            n_out.vel_z  = pz[47:16];
            n_out.update = 1'b1;
        end else begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// File: src/radial_impact_velocity_profile.sv
// top level of the radial impact velocity block: configuration registers and pipeline control
// depends on rivp_pkg, rivp_geom, rivp_shape, rivp_scale
//
// usage:
// - input channel: i_valid / o_stall with i_in carrying node_x and node_y (signed Q8.24);
//   a transaction happens at a clock edge with i_valid high and o_stall low
// - output channel: o_valid / i_stall with o_out carrying vel_x, vel_y, vel_z (Q16.16)
//   and update; a transaction happens with o_valid high and i_stall low
// - configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx, write only while idle
// - one node per cycle sustained while the output is not stalled
// - eight register stages: offset, squares, r2/cutoff, r2 times inv_sigma_sq, saturation,
//   table read, interpolation, coefficient scaling into the output register
// - the whole pipeline advances together; it holds only when the output register is
//   full and the receiver stalls, and o_stall follows that condition
// - reset clears all valid bits and restores register defaults (inv_sigma_sq 1.0,
//   cutoff disabled, gaussian shape, zero coefficients and centre)
module radial_impact_velocity_profile (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  rivp_pkg::t_in_item             i_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output rivp_pkg::t_out_item            o_out,
    input  logic                           i_cfg_we,
    input  logic [rivp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);
    import rivp_pkg::*;

    t_cfg            r_cfg;
    logic            en;
    t_ctl            geom_ctl, shape_ctl;
    logic [R2_W-1:0] r2;
    logic [P_W-1:0]  p;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctr_x        <= '0;
            r_cfg.ctr_y        <= '0;
            r_cfg.inv_sigma_sq <= 32'h0001_0000;
            r_cfg.cutoff_sq    <= 32'hFFFF_FFFF;
            r_cfg.shape_mode   <= SHAPE_GAUSS;
            r_cfg.coef_x       <= '0;
            r_cfg.coef_y       <= '0;
            r_cfg.coef_z       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X:     r_cfg.ctr_x        <= i_cfg_data;
                REG_CENTER_Y:     r_cfg.ctr_y        <= i_cfg_data;
                REG_INV_SIGMA_SQ: r_cfg.inv_sigma_sq <= i_cfg_data;
                REG_CUTOFF_SQ:    r_cfg.cutoff_sq    <= i_cfg_data;
                REG_SHAPE_MODE:   r_cfg.shape_mode   <= i_cfg_data[1:0];
                REG_COEF_X:       r_cfg.coef_x       <= i_cfg_data;
                REG_COEF_Y:       r_cfg.coef_y       <= i_cfg_data;
                REG_COEF_Z:       r_cfg.coef_z       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rivp_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_ctl   (geom_ctl),
        .o_r2    (r2)
    );

    rivp_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geom_ctl),
        .i_r2    (r2),
        .i_cfg   (r_cfg),
        .o_ctl   (shape_ctl),
        .o_p     (p)
    );

    rivp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (shape_ctl),
        .i_p     (p),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule
